### rtl/assert_macros.svh
// Assertion helpers for the duty calculator. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SVDC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SVDC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/svdc_pkg.sv
// ----------------------------------------------------------------------------
// svdc_pkg: space vector duty calculator package
// Item types, register codes and fixed-point constants used by the top level.
// ----------------------------------------------------------------------------
package svdc_pkg;

  localparam int VOLT_BITS = 16;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_BUS_VOLTAGE  = 2'd0;
  localparam logic [1:0] REG_MAX_INDEX    = 2'd1;
  localparam logic [1:0] REG_TIMER_PERIOD = 2'd2;

  localparam logic [15:0] RST_BUS_VOLTAGE  = 16'd32767;
  localparam logic [15:0] RST_MAX_INDEX    = 16'd32768;
  localparam logic [15:0] RST_TIMER_PERIOD = 16'd1000;

  localparam logic [15:0]        Q15_ONE   = 16'h8000;
  localparam logic signed [16:0] SIN60_Q16 = 17'sd56756;

  // Sector codes
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;
  localparam logic [2:0] SEC_6 = 3'd6;

  typedef struct packed {
    logic signed [VOLT_BITS-1:0] v_alpha;
    logic signed [VOLT_BITS-1:0] v_beta;
  } in_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector;
  } out_t;

endpackage

### rtl/svdc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// svdc_sqrt_cell: one step of the integer square root chain
// Tries one root bit, keeps the remainder, registers everything.
// ----------------------------------------------------------------------------
module svdc_sqrt_cell #(
  parameter int W      = 32,
  parameter int BITPOS = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic [W-1:0]      rem_i,
  input  logic [W-1:0]      root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [W-1:0]      rem_o,
  output logic [W-1:0]      root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [W:0]        trial_w;
  logic              take_w;
  logic [W-1:0]      rem_nxt;
  logic [W-1:0]      root_nxt;
  logic              vld_r;
  logic [W-1:0]      rem_r;
  logic [W-1:0]      root_r;
  logic [SIDE_W-1:0] side_r;

  assign trial_w  = (W+1)'(root_i) + ((W+1)'(1) << BITPOS);
  assign take_w   = (W+1)'(rem_i) >= trial_w;
  assign rem_nxt  = take_w ? rem_i - trial_w[W-1:0] : rem_i;
  assign root_nxt = take_w ? (root_i >> 1) + (W'(1) << BITPOS) : root_i >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

### rtl/svdc_div_cell.sv
// ----------------------------------------------------------------------------
// svdc_div_cell: one step of a restoring divider chain
// Tests the shifted divisor against the remainder and sets one quotient bit.
// ----------------------------------------------------------------------------
module svdc_div_cell #(
  parameter int NW     = 32,
  parameter int DW     = 16,
  parameter int QW     = 17,
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic [NW-1:0]     rem_i,
  input  logic [DW-1:0]     dvs_i,
  input  logic [QW-1:0]     quo_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [NW-1:0]     rem_o,
  output logic [DW-1:0]     dvs_o,
  output logic [QW-1:0]     quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int CW = (NW > DW + SHIFT) ? NW : DW + SHIFT;

  logic [CW-1:0]     sub_w;
  logic              take_w;
  logic [NW-1:0]     rem_nxt;
  logic [QW-1:0]     quo_nxt;
  logic              vld_r;
  logic [NW-1:0]     rem_r;
  logic [DW-1:0]     dvs_r;
  logic [QW-1:0]     quo_r;
  logic [SIDE_W-1:0] side_r;

  assign sub_w   = CW'(dvs_i) << SHIFT;
  assign take_w  = CW'(rem_i) >= sub_w;
  assign rem_nxt = take_w ? rem_i - sub_w[NW-1:0] : rem_i;
  assign quo_nxt = take_w ? (quo_i | (QW'(1) << SHIFT)) : quo_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_i;
    quo_r  <= quo_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign dvs_o  = dvs_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

### rtl/space_vector_duty_calculator_top.sv
// ----------------------------------------------------------------------------
// space_vector_duty_calculator_top: space vector PWM duty calculator
// Turns one (alpha, beta) voltage item into three compare counts and a sector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_data and raise start; the item is taken at any
//   clock edge where start is high and busy is low. busy stays low, so a new
//   item may enter on every cycle.
//   Result channel: out_valid is high for exactly one cycle with out_data;
//   the receiver has to take it then, there is no way to stall the block.
//   Throughput is one item per cycle. The pipeline is a row of registered
//   cells: one cell per root bit in the square root chain, 17 cells in the
//   modulation index divider and 18 in each active time divider, plus seven
//   plain pipeline stages.
//   Configuration: APB writes to bus_voltage (0x0), max_index (0x4) and
//   timer_period (0x8); write them only while no item is in flight.
//   Reset (synchronous, rst_n low) empties the pipeline and loads the
//   register defaults: bus 32767, index limit 1.0, period 1000.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module space_vector_duty_calculator_top (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              start,
  output logic              busy,
  input  svdc_pkg::in_t     in_data,
  // result channel
  output logic              out_valid,
  output svdc_pkg::out_t    out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int VB      = svdc_pkg::VOLT_BITS;
  localparam int SQ_W    = 2 * VB;          // sum of squares
  localparam int XS_W    = VB + 17;         // alpha times sin60
  localparam int PROJ_W  = VB + 18;         // signed boundary projection
  localparam int PA_W    = VB + 17;         // positive projection
  localparam int SQ_SIDE = XS_W + VB;
  localparam int MD_NW   = VB + 15;
  localparam int MD_QW   = 17;
  localparam int MD_SIDE = 1 + 3 + 2 * PA_W + VB;
  localparam int TD_QW   = 18;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] bus_voltage_r;
  logic [15:0] max_index_r;
  logic [15:0] timer_period_r;
  logic        cfg_wr_w;

  assign pready   = 1'b1;
  assign cfg_wr_w = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_voltage_r  <= svdc_pkg::RST_BUS_VOLTAGE;
      max_index_r    <= svdc_pkg::RST_MAX_INDEX;
      timer_period_r <= svdc_pkg::RST_TIMER_PERIOD;
    end else if (cfg_wr_w) begin
      unique case (paddr[3:2])
        svdc_pkg::REG_BUS_VOLTAGE:  bus_voltage_r  <= pwdata[15:0];
        svdc_pkg::REG_MAX_INDEX:    max_index_r    <= pwdata[15:0];
        svdc_pkg::REG_TIMER_PERIOD: timer_period_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      svdc_pkg::REG_BUS_VOLTAGE:  prdata = {16'd0, bus_voltage_r};
      svdc_pkg::REG_MAX_INDEX:    prdata = {16'd0, max_index_r};
      svdc_pkg::REG_TIMER_PERIOD: prdata = {16'd0, timer_period_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 1: squares and alpha * sin60
  // --------------------------------------------------------------------------
  logic                   accept_w;
  logic [VB-1:0]          ax_w, ay_w;
  logic                   s1_vld_r;
  logic [SQ_W-1:0]        s1_sqx_r, s1_sqy_r;
  logic signed [XS_W-1:0] s1_xs_r;
  logic signed [VB-1:0]   s1_y_r;

  assign busy     = 1'b0;
  assign accept_w = start && !busy;
  assign ax_w = in_data.v_alpha[VB-1] ? (~in_data.v_alpha + 1'b1) : in_data.v_alpha;
  assign ay_w = in_data.v_beta[VB-1]  ? (~in_data.v_beta + 1'b1)  : in_data.v_beta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept_w;
    end
  end

  always_ff @(posedge clk) begin
    s1_sqx_r <= SQ_W'(ax_w) * SQ_W'(ax_w);
    s1_sqy_r <= SQ_W'(ay_w) * SQ_W'(ay_w);
    s1_xs_r  <= XS_W'(in_data.v_alpha) * XS_W'(svdc_pkg::SIN60_Q16);
    s1_y_r   <= in_data.v_beta;
  end

  // --------------------------------------------------------------------------
  // Square root chain: one cell per magnitude bit
  // --------------------------------------------------------------------------
  logic                sq_vld  [VB+1];
  logic [SQ_W-1:0]     sq_rem  [VB+1];
  logic [SQ_W-1:0]     sq_root [VB+1];
  logic [SQ_SIDE-1:0]  sq_side [VB+1];

  assign sq_vld[0]  = s1_vld_r;
  assign sq_rem[0]  = s1_sqx_r + s1_sqy_r;
  assign sq_root[0] = '0;
  assign sq_side[0] = {s1_xs_r, s1_y_r};

  for (genvar i = 0; i < VB; i++) begin : g_sqrt
    svdc_sqrt_cell #(
      .W      (SQ_W),
      .BITPOS (2 * (VB - 1 - i)),
      .SIDE_W (SQ_SIDE)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (sq_vld[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_vld[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 2: boundary projections and sector search
  // --------------------------------------------------------------------------
  logic [VB-1:0]            mag_w;
  logic signed [XS_W-1:0]   xs_w;
  logic signed [VB-1:0]     y_w;
  logic signed [PROJ_W-1:0] xe_w, y15_w, y16_w;
  logic signed [PROJ_W-1:0] proj_w [7];
  logic                     found_w;
  logic [2:0]               sec_w;
  logic [PA_W-1:0]          pa_w, pb_w;
  logic                     p_vld_r;
  logic [2:0]               p_sec_r;
  logic [PA_W-1:0]          p_pa_r, p_pb_r;
  logic [VB-1:0]            p_mag_r;
  logic                     p_zero_r;

  assign mag_w = sq_root[VB][VB-1:0];
  assign xs_w  = sq_side[VB][SQ_SIDE-1:VB];
  assign y_w   = sq_side[VB][VB-1:0];
  assign xe_w  = PROJ_W'(xs_w);
  assign y15_w = PROJ_W'(y_w) <<< 15;
  assign y16_w = PROJ_W'(y_w) <<< 16;

  // x*sin(60i) - y*cos(60i) at each sector edge
  assign proj_w[0] = -y16_w;
  assign proj_w[1] = xe_w - y15_w;
  assign proj_w[2] = xe_w + y15_w;
  assign proj_w[3] = y16_w;
  assign proj_w[4] = y15_w - xe_w;
  assign proj_w[5] = -xe_w - y15_w;
  assign proj_w[6] = -y16_w;

  // First sector whose leading edge lies ahead and trailing edge behind
  always_comb begin
    found_w = 1'b0;
    sec_w   = svdc_pkg::SEC_1;
    pa_w    = '0;
    pb_w    = '0;
    for (int k = 1; k <= 6; k++) begin
      if (!found_w && (proj_w[k] > 0) && (proj_w[k-1] <= 0)) begin
        found_w = 1'b1;
        sec_w   = 3'(k);
        pa_w    = PA_W'(proj_w[k]);
        pb_w    = PA_W'(-proj_w[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= sq_vld[VB];
    end
  end

  always_ff @(posedge clk) begin
    p_sec_r  <= sec_w;
    p_pa_r   <= pa_w;
    p_pb_r   <= pb_w;
    p_mag_r  <= mag_w;
    p_zero_r <= (mag_w == '0) || !found_w;
  end

  // --------------------------------------------------------------------------
  // Modulation index divider: magnitude * 2^15 / bus voltage
  // --------------------------------------------------------------------------
  logic               md_vld  [MD_QW+1];
  logic [MD_NW-1:0]   md_rem  [MD_QW+1];
  logic [15:0]        md_dvs  [MD_QW+1];
  logic [MD_QW-1:0]   md_quo  [MD_QW+1];
  logic [MD_SIDE-1:0] md_side [MD_QW+1];

  assign md_vld[0]  = p_vld_r;
  assign md_rem[0]  = {p_mag_r, 15'd0};
  assign md_dvs[0]  = bus_voltage_r;
  assign md_quo[0]  = '0;
  assign md_side[0] = {p_zero_r, p_sec_r, p_pa_r, p_pb_r, p_mag_r};

  for (genvar i = 0; i < MD_QW; i++) begin : g_mdiv
    svdc_div_cell #(
      .NW     (MD_NW),
      .DW     (16),
      .QW     (MD_QW),
      .SHIFT  (MD_QW - 1 - i),
      .SIDE_W (MD_SIDE)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (md_vld[i]),
      .rem_i  (md_rem[i]),
      .dvs_i  (md_dvs[i]),
      .quo_i  (md_quo[i]),
      .side_i (md_side[i]),
      .vld_o  (md_vld[i+1]),
      .rem_o  (md_rem[i+1]),
      .dvs_o  (md_dvs[i+1]),
      .quo_o  (md_quo[i+1]),
      .side_o (md_side[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 3: saturate the index
  // --------------------------------------------------------------------------
  logic [15:0]     limit_w;
  logic [MD_QW-1:0] mq_w;
  logic [15:0]     m_nxt;
  logic            m_vld_r;
  logic [15:0]     m_r;
  logic            m_zero_r;
  logic [2:0]      m_sec_r;
  logic [PA_W-1:0] m_pa_r, m_pb_r;
  logic [VB-1:0]   m_mag_r;

  assign limit_w = (max_index_r > svdc_pkg::Q15_ONE) ? svdc_pkg::Q15_ONE : max_index_r;
  assign mq_w    = md_quo[MD_QW];
  // A set top bit means the quotient overflowed (also a zero bus voltage)
  assign m_nxt   = (mq_w[MD_QW-1] || (mq_w[15:0] > limit_w)) ? limit_w : mq_w[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= md_vld[MD_QW];
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    {m_zero_r, m_sec_r, m_pa_r, m_pb_r, m_mag_r} <= md_side[MD_QW];
  end

  // --------------------------------------------------------------------------
  // Stage 4: projection times index, dropped by 2^16
  // --------------------------------------------------------------------------
  logic [PA_W+15:0] prod_a_w, prod_b_w;
  logic             mu_vld_r;
  logic [PA_W-1:0]  mu_na_r, mu_nb_r;
  logic [VB-1:0]    mu_mag_r;
  logic             mu_zero_r;
  logic [2:0]       mu_sec_r;

  assign prod_a_w = (PA_W+16)'(m_pa_r) * (PA_W+16)'(m_r);
  assign prod_b_w = (PA_W+16)'(m_pb_r) * (PA_W+16)'(m_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_vld_r <= 1'b0;
    end else begin
      mu_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    mu_na_r   <= prod_a_w[PA_W+15:16];
    mu_nb_r   <= prod_b_w[PA_W+15:16];
    mu_mag_r  <= m_mag_r;
    mu_zero_r <= m_zero_r;
    mu_sec_r  <= m_sec_r;
  end

  // --------------------------------------------------------------------------
  // Active time dividers: two lanes in lockstep, divide by magnitude
  // --------------------------------------------------------------------------
  logic              ta_vld  [TD_QW+1];
  logic [PA_W-1:0]   ta_rem  [TD_QW+1];
  logic [VB-1:0]     ta_dvs  [TD_QW+1];
  logic [TD_QW-1:0]  ta_quo  [TD_QW+1];
  logic [2:0]        ta_side [TD_QW+1];
  logic              tb_vld  [TD_QW+1];
  logic [PA_W-1:0]   tb_rem  [TD_QW+1];
  logic [VB-1:0]     tb_dvs  [TD_QW+1];
  logic [TD_QW-1:0]  tb_quo  [TD_QW+1];
  logic [0:0]        tb_side [TD_QW+1];

  assign ta_vld[0]  = mu_vld_r;
  assign ta_rem[0]  = mu_na_r;
  assign ta_dvs[0]  = mu_mag_r;
  assign ta_quo[0]  = '0;
  assign ta_side[0] = mu_sec_r;
  assign tb_vld[0]  = mu_vld_r;
  assign tb_rem[0]  = mu_nb_r;
  assign tb_dvs[0]  = mu_mag_r;
  assign tb_quo[0]  = '0;
  assign tb_side[0] = mu_zero_r;

  for (genvar i = 0; i < TD_QW; i++) begin : g_tdiv
    svdc_div_cell #(
      .NW     (PA_W),
      .DW     (VB),
      .QW     (TD_QW),
      .SHIFT  (TD_QW - 1 - i),
      .SIDE_W (3)
    ) u_lane_a (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (ta_vld[i]),
      .rem_i  (ta_rem[i]),
      .dvs_i  (ta_dvs[i]),
      .quo_i  (ta_quo[i]),
      .side_i (ta_side[i]),
      .vld_o  (ta_vld[i+1]),
      .rem_o  (ta_rem[i+1]),
      .dvs_o  (ta_dvs[i+1]),
      .quo_o  (ta_quo[i+1]),
      .side_o (ta_side[i+1])
    );

    svdc_div_cell #(
      .NW     (PA_W),
      .DW     (VB),
      .QW     (TD_QW),
      .SHIFT  (TD_QW - 1 - i),
      .SIDE_W (1)
    ) u_lane_b (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (tb_vld[i]),
      .rem_i  (tb_rem[i]),
      .dvs_i  (tb_dvs[i]),
      .quo_i  (tb_quo[i]),
      .side_i (tb_side[i]),
      .vld_o  (tb_vld[i+1]),
      .rem_o  (tb_rem[i+1]),
      .dvs_o  (tb_dvs[i+1]),
      .quo_o  (tb_quo[i+1]),
      .side_o (tb_side[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 5: clamp active times, form the zero time
  // --------------------------------------------------------------------------
  logic [TD_QW-1:0] qa_w, qb_w;
  logic [15:0]      t1_w, t2_w;
  logic [16:0]      tsum_w;
  logic             t_vld_r;
  logic [15:0]      t1_r, t2_r, t0_r;
  logic [2:0]       t_sec_r;

  assign qa_w   = ta_quo[TD_QW];
  assign qb_w   = tb_quo[TD_QW];
  // Degenerate vector: no active time at all
  assign t1_w   = tb_side[TD_QW][0] ? 16'd0 :
                  (qa_w > TD_QW'(svdc_pkg::Q15_ONE)) ? svdc_pkg::Q15_ONE : qa_w[15:0];
  assign t2_w   = tb_side[TD_QW][0] ? 16'd0 :
                  (qb_w > TD_QW'(svdc_pkg::Q15_ONE)) ? svdc_pkg::Q15_ONE : qb_w[15:0];
  assign tsum_w = 17'(t1_w) + 17'(t2_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else begin
      t_vld_r <= ta_vld[TD_QW];
    end
  end

  always_ff @(posedge clk) begin
    t1_r    <= t1_w;
    t2_r    <= t2_w;
    t0_r    <= (tsum_w >= 17'(svdc_pkg::Q15_ONE)) ? 16'd0
                                                  : 16'(17'(svdc_pkg::Q15_ONE) - tsum_w);
    t_sec_r <= ta_side[TD_QW];
  end

  // --------------------------------------------------------------------------
  // Stage 6: scale times by the timer period
  // --------------------------------------------------------------------------
  logic [31:0] sc1_w, sc2_w, sc0_w;
  logic        sc_vld_r;
  logic [16:0] sc1_r, sc2_r, sc0_r;
  logic [2:0]  sc_sec_r;

  assign sc1_w = t1_r * timer_period_r;
  assign sc2_w = t2_r * timer_period_r;
  assign sc0_w = t0_r * timer_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else begin
      sc_vld_r <= t_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sc1_r    <= sc1_w[31:15];
    sc2_r    <= sc2_w[31:15];
    sc0_r    <= sc0_w[31:15];
    sc_sec_r <= t_sec_r;
  end

  // --------------------------------------------------------------------------
  // Stage 7: map per sector, saturate at the period, drive the result
  // --------------------------------------------------------------------------
  logic [17:0]    h_w, s1h_w, s2h_w, s12h_w;
  logic [17:0]    da_w, db_w, dc_w;
  logic           out_valid_r;
  svdc_pkg::out_t out_data_r;

  assign h_w    = 18'(sc0_r >> 1);
  assign s1h_w  = 18'(sc1_r) + h_w;
  assign s2h_w  = 18'(sc2_r) + h_w;
  assign s12h_w = 18'(sc1_r) + s2h_w;

  always_comb begin
    unique case (sc_sec_r)
      svdc_pkg::SEC_1: begin da_w = s12h_w; db_w = s2h_w;  dc_w = h_w;    end
      svdc_pkg::SEC_2: begin da_w = s1h_w;  db_w = s12h_w; dc_w = h_w;    end
      svdc_pkg::SEC_3: begin da_w = h_w;    db_w = s12h_w; dc_w = s2h_w;  end
      svdc_pkg::SEC_4: begin da_w = h_w;    db_w = s1h_w;  dc_w = s12h_w; end
      svdc_pkg::SEC_5: begin da_w = s2h_w;  db_w = h_w;    dc_w = s12h_w; end
      default:         begin da_w = s12h_w; db_w = h_w;    dc_w = s1h_w;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sc_vld_r;
    end
  end

  // Clip each count at the period; rounding can push a sum past it
  always_ff @(posedge clk) begin
    out_data_r.duty_a <= (da_w > 18'(timer_period_r)) ? timer_period_r : da_w[15:0];
    out_data_r.duty_b <= (db_w > 18'(timer_period_r)) ? timer_period_r : db_w[15:0];
    out_data_r.duty_c <= (dc_w > 18'(timer_period_r)) ? timer_period_r : dc_w[15:0];
    out_data_r.sector <= sc_sec_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SVDC_ASSERT_NXT(a_accept_enters, accept_w, s1_vld_r, "accepted item did not enter stage 1")
  `SVDC_ASSERT_IMP(a_lanes_lockstep, ta_vld[TD_QW] || tb_vld[TD_QW], ta_vld[TD_QW] && tb_vld[TD_QW], "active time lanes out of step")
  `SVDC_ASSERT_IMP(a_sector_range, out_valid_r, (out_data_r.sector >= svdc_pkg::SEC_1) && (out_data_r.sector <= svdc_pkg::SEC_6), "sector out of range")
  `SVDC_ASSERT_IMP(a_duty_bound, out_valid_r, (out_data_r.duty_a <= timer_period_r) && (out_data_r.duty_b <= timer_period_r) && (out_data_r.duty_c <= timer_period_r), "duty above timer period")

endmodule
